@@ rtl/lasp_pkg.sv @@
// shared types and constants of the latency aware batch size picker
`default_nettype none
package lasp_pkg;

   localparam int ENTRY_W  = 24;
   localparam int SIZE_W   = 9;
   localparam int LIMIT_W  = 6;
   localparam int BOUND_W  = 16;
   localparam int WEIGHT_W = 17;
   localparam int QUEUE_W  = 16;
   localparam int BSIZE_W  = 8;
   localparam int CSR_W    = 17;
   localparam int CSR_A_W  = 2;

   localparam logic [CSR_A_W-1:0] CSR_BATCH_LIMIT = 2'd0;
   localparam logic [CSR_A_W-1:0] CSR_BOUND       = 2'd1;
   localparam logic [CSR_A_W-1:0] CSR_WEIGHT      = 2'd2;

   localparam logic KIND_UPDATE = 1'b0;
   localparam logic KIND_QUERY  = 1'b1;

   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 17'd65536;
   // default prediction (10 + 5 * size) ms in 1/256 ms, built from slot index k as (15 + 5k)
   localparam int DEF_BASE_MS = 15;

   typedef struct packed {
      logic                kind;
      logic                upd_en;
      logic [BSIZE_W-1:0]  size;
      logic [ENTRY_W-1:0]  lat;
      logic [SIZE_W-1:0]   start;
   } item_type;

   typedef struct packed {
      logic [ENTRY_W-1:0]  wr_data;
      logic                qualify;
   } head_out_type;

endpackage
`default_nettype wire

@@ rtl/lasp_cell.sv @@
// one table entry of the latency ring, shifts toward the head while scanning
`default_nettype none
module lasp_cell (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              shift,
   input  wire  [lasp_pkg::ENTRY_W-1:0]     d_in,
   output logic [lasp_pkg::ENTRY_W-1:0]     q
);
   import lasp_pkg::*;

   logic [ENTRY_W-1:0] entry_ff;
   logic [ENTRY_W-1:0] entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (shift) begin
         entry_in = d_in;
      end
   end

   // zero means unseen
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign q = entry_ff;

endmodule
`default_nettype wire

@@ rtl/lasp_head.sv @@
// head of the ring: moving average update and prediction test for the entry at the head
`default_nettype none
module lasp_head (
   input  wire  [lasp_pkg::ENTRY_W-1:0]     entry,
   input  wire  [lasp_pkg::SIZE_W-1:0]      slot_size,
   input  lasp_pkg::item_type               item,
   input  wire  [lasp_pkg::BOUND_W-1:0]     bound_ms,
   input  wire  [lasp_pkg::WEIGHT_W-1:0]    weight,
   output lasp_pkg::head_out_type           head_out
);
   import lasp_pkg::*;

   logic [WEIGHT_W-1:0]     w_sat;
   logic signed [ENTRY_W:0] diff;
   logic signed [ENTRY_W+WEIGHT_W+1:0] prod;
   logic signed [ENTRY_W+2:0] step;
   logic [ENTRY_W+2:0]      sum;
   logic [ENTRY_W-1:0]      blended;
   logic [SIZE_W+2:0]       k5;
   logic [ENTRY_W-1:0]      pred;
   logic [ENTRY_W-1:0]      bound_q8;
   logic                    hit;

   always_comb begin
      w_sat = (weight > WEIGHT_ONE) ? WEIGHT_ONE : weight;
      // old + floor(w * (lat - old) / 2^16) equals the truncated blend
      diff  = $signed({1'b0, item.lat}) - $signed({1'b0, entry});
      prod  = $signed({1'b0, w_sat}) * diff;
      step  = prod[ENTRY_W+WEIGHT_W+1:16];
      sum   = (ENTRY_W+3)'(entry) + $unsigned(step);
      blended = sum[ENTRY_W-1:0];

      hit = (item.kind == KIND_UPDATE) && item.upd_en
            && (slot_size == {1'b0, item.size});
      head_out.wr_data = hit ? blended : entry;

      // slot index k = slot_size - 1
      k5 = ((SIZE_W+3)'(slot_size) - (SIZE_W+3)'(1)) * (SIZE_W+3)'(5);
      if (entry != '0) begin
         pred = entry;
      end else begin
         pred = {ENTRY_W'(k5) + ENTRY_W'(DEF_BASE_MS)} << 8;
      end
      bound_q8 = {bound_ms, 8'd0};
      head_out.qualify = (item.kind == KIND_QUERY) && (slot_size <= item.start)
                         && (pred < bound_q8);
   end

endmodule
`default_nettype wire

@@ rtl/latency_aware_batch_size_picker_top.sv @@
// top level: ring of latency cells, head unit, item sequencing and result register
// Latency aware batch size picker.
// req channel: tuser carries kind (0 record a latency, 1 ask for a batch size);
// tdata carries bsize, latency and queue_length. rsp channel returns one beat
// with chosen_size for every query and nothing for an update.
// csr port: csr_we writes csr_wdata into register csr_addr (0 batch_limit,
// 1 latency_bound_ms, 2 ema_weight); the user must write only while the block is
// idle, as the block itself does not enforce it. The MAX_BATCH entries sit in a
// ring of cells that rotates one place per cycle while an item is scanned, past a
// single head unit, so every item takes a full turn of the ring. After the turn an
// update is done and a query's rsp beat is loaded from a hold state. A new req beat
// is taken only while idle, so no item is taken before the last has made its turn.
// The rsp beat sits in an output register, so req is taken again while it waits;
// if a later query finishes while the old beat is still stalled, the block holds
// the new answer and takes no req beat until rsp_tready frees the register.
// Reset clears all entries to unseen and loads the register defaults.
`default_nettype none
module latency_aware_batch_size_picker_top #(
   parameter int MAX_BATCH = 32
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [47:0] req_tdata,   // bsize[7:0], latency[31:8], queue_length[47:32]
   input  wire  [0:0]  req_tuser,   // kind[0]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [7:0]  rsp_tdata,   // chosen_size[5:0], zero pad[7:6]
   input  wire         csr_we,
   input  wire  [lasp_pkg::CSR_A_W-1:0] csr_addr,
   input  wire  [lasp_pkg::CSR_W-1:0]   csr_wdata
);
   import lasp_pkg::*;

   localparam int CW = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
   localparam logic [CW-1:0] LAST_K = CW'(MAX_BATCH - 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_HOLD = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [CW-1:0]       k_ff, k_in;
   item_type            item_ff, item_in;
   logic [SIZE_W-1:0]   chosen_ff, chosen_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [LIMIT_W-1:0]  rsp_size_ff, rsp_size_in;
   logic [LIMIT_W-1:0]  limit_ff, limit_in;
   logic [BOUND_W-1:0]  bound_ff, bound_in;
   logic [WEIGHT_W-1:0] weight_ff, weight_in;

   logic [ENTRY_W-1:0]  ring_q [MAX_BATCH];
   logic                shift;
   logic [SIZE_W-1:0]   slot_size;
   logic [SIZE_W-1:0]   eff_lim;
   logic [SIZE_W-1:0]   start;
   logic [BSIZE_W-1:0]  in_size;
   logic [QUEUE_W-1:0]  in_queue;
   logic                accept;
   logic                out_free;
   head_out_type        head_out;

   assign shift     = (state_ff == ST_SCAN);
   assign slot_size = SIZE_W'(k_ff) + SIZE_W'(1);
   assign in_size   = req_tdata[7:0];
   assign in_queue  = req_tdata[47:32];
   assign eff_lim   = ((SIZE_W)'(limit_ff) > SIZE_W'(MAX_BATCH)) ? SIZE_W'(MAX_BATCH)
                                                               : SIZE_W'(limit_ff);
   assign start     = ((QUEUE_W)'(eff_lim) < in_queue) ? eff_lim : SIZE_W'(in_queue);
   assign accept    = req_tvalid && req_tready;
   assign out_free  = !rsp_valid_ff || rsp_tready;

   genvar gi;
   generate
      for (gi = 0; gi < MAX_BATCH; gi++) begin : g_ring
         if (gi == MAX_BATCH - 1) begin : g_tail
            lasp_cell u_cell (
               .clock (clock),
               .reset (reset),
               .shift (shift),
               .d_in  (head_out.wr_data),
               .q     (ring_q[gi])
            );
         end else begin : g_mid
            lasp_cell u_cell (
               .clock (clock),
               .reset (reset),
               .shift (shift),
               .d_in  (ring_q[gi+1]),
               .q     (ring_q[gi])
            );
         end
      end
   endgenerate

   lasp_head u_head (
      .entry          (ring_q[0]),
      .slot_size      (slot_size),
      .item           (item_ff),
      .bound_ms       (bound_ff),
      .weight         (weight_ff),
      .head_out       (head_out)
   );

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      item_in      = item_ff;
      chosen_in    = chosen_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_size_in  = rsp_size_ff;
      limit_in     = limit_ff;
      bound_in     = bound_ff;
      weight_in    = weight_ff;
      req_tready   = (state_ff == ST_IDLE);

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               item_in.kind   = req_tuser[0];
               item_in.size   = in_size;
               item_in.lat    = req_tdata[31:8];
               item_in.start  = start;
               item_in.upd_en = (in_size != '0) && ((SIZE_W)'(in_size) <= eff_lim);
               chosen_in      = SIZE_W'(1);
               k_in           = '0;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (head_out.qualify) begin
               chosen_in = slot_size;
            end
            if (k_ff == LAST_K) begin
               k_in     = '0;
               state_in = (item_ff.kind == KIND_QUERY) ? ST_HOLD : ST_IDLE;
            end else begin
               k_in = k_ff + CW'(1);
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_size_in  = chosen_ff[LIMIT_W-1:0];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_we) begin
         case (csr_addr)
            CSR_BATCH_LIMIT: limit_in  = csr_wdata[LIMIT_W-1:0];
            CSR_BOUND:       bound_in  = csr_wdata[BOUND_W-1:0];
            CSR_WEIGHT:      weight_in = csr_wdata[WEIGHT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
         limit_ff     <= LIMIT_W'(32);
         bound_ff     <= BOUND_W'(100);
         weight_ff    <= WEIGHT_W'(6554);
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
         limit_ff     <= limit_in;
         bound_ff     <= bound_in;
         weight_ff    <= weight_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      chosen_ff   <= chosen_in;
      rsp_size_ff <= rsp_size_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_size_ff};

endmodule
`default_nettype wire
